[hdl/kbf_pkg.sv]
// ----------------------------------------------------------------------------
// kbf_pkg
// Shared constants, types and helpers of the k-mer Bloom filter engine.
// ----------------------------------------------------------------------------
package kbf_pkg;

    localparam logic [63:0] MIX_MUL      = 64'hc6a4a7935bd1e995;
    localparam int          MIX_SHIFT    = 47;
    localparam int          FILTER_BITS_DEF = 1048576;
    localparam int          MAX_KMER_DEF = 64;
    localparam logic [1:0]  MUL_LAST     = 2'd2;

    localparam logic [6:0]  KMER_LEN_RST    = 7'd15;
    localparam logic [4:0]  HASH_COUNT_RST  = 5'd5;
    localparam logic [20:0] FILTER_SIZE_RST = 21'd1048576;

    localparam logic [1:0]  REG_KMER_LEN    = 2'd0;
    localparam logic [1:0]  REG_HASH_COUNT  = 2'd1;
    localparam logic [1:0]  REG_FILTER_SIZE = 2'd2;

    localparam logic        CMD_INSERT = 1'b0;
    localparam logic        CMD_QUERY  = 1'b1;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_RECV, ST_CRD, ST_CCMP, ST_HINIT, ST_MUL, ST_HSEED,
        ST_BRD, ST_BSH, ST_K1, ST_K2, ST_HM, ST_FIN1, ST_FIN2, ST_DIV,
        ST_MRD, ST_MUPD, ST_RESP
    } state_t;

    function automatic logic [7:0] comp_base(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h41:   r = 8'h54;
            8'h43:   r = 8'h47;
            8'h47:   r = 8'h43;
            8'h54:   r = 8'h41;
            default: r = 8'h4e;
        endcase
        return r;
    endfunction

endpackage

[hdl/kbf_mul.sv]
// ----------------------------------------------------------------------------
// kbf_mul
// Multiply a 64-bit operand by the mix constant, modulo 2^64, as a sum of
// low-by-low, low-by-high and high-by-low partial products on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module kbf_mul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] a,
    output logic        done,
    output logic [63:0] prod
);

    logic [63:0] a_reg;
    logic [63:0] prod_reg, prod_next;
    logic [1:0]  ph_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] mx, my;
    logic [63:0] p;

    assign mx = (ph_reg == kbf_pkg::MUL_LAST) ? a_reg[63:32] : a_reg[31:0];
    assign my = (ph_reg == 2'd1) ? kbf_pkg::MIX_MUL[63:32] : kbf_pkg::MIX_MUL[31:0];
    assign p  = 64'(mx) * 64'(my);

    always_comb begin
        if (ph_reg == 2'd0) begin
            prod_next = p;
        end else begin
            prod_next = prod_reg + {p[31:0], 32'd0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ph_reg   <= 2'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                ph_reg   <= 2'd0;
            end else if (busy_reg) begin
                ph_reg <= ph_reg + 2'd1;
                if (ph_reg == kbf_pkg::MUL_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= a;
        end
        if (busy_reg) begin
            prod_reg <= prod_next;
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

[hdl/kmer_bloom_filter_engine.sv]
// ----------------------------------------------------------------------------
// kmer_bloom_filter_engine
// Canonical k-mer Bloom filter: insert and query with MurmurHash2-64 probes.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while the engine is receiving; after the last
// byte it is busy with the canonical compare, then per seed with the hash, each
// multiply run on the shared 32x32 unit, the bit-serial modulo and the store
// read and update. A query stops at its first clear bit; a wrong-length k-mer
// answers without compare or hashing. After reset the store is cleared one
// 64-bit row a cycle.
module kmer_bloom_filter_engine #(
    parameter int FILTER_BITS = kbf_pkg::FILTER_BITS_DEF,
    parameter int MAX_KMER    = kbf_pkg::MAX_KMER_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // key_byte
    input  logic        s_tuser,   // cmd
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // present, length_error, zeros
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int ROWS = (FILTER_BITS + 63) / 64;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int RCW  = $clog2(ROWS + 1);
    localparam int MW   = ($clog2(FILTER_BITS) + 1 > 22) ? $clog2(FILTER_BITS) + 1 : 22;
    localparam int AW   = $clog2(MAX_KMER);
    localparam int CW   = $clog2(MAX_KMER + 2);
    localparam int LW   = (CW > 7) ? CW : 7;

    kbf_pkg::state_t state_reg, state_next, ret_reg, ret_next;

    logic [6:0]    kmer_len_reg;
    logic [4:0]    hash_count_reg;
    logic [20:0]   filter_size_reg;

    logic [CW-1:0] cnt_reg, cnt_next, cnt_inc;
    logic [CW-1:0] len_reg, len_next;
    logic [CW-1:0] idx_reg, idx_next, idx_inc;
    logic          cmd_reg, cmd_next;
    logic          err_reg, err_next, len_bad;
    logic          flip_reg, flip_next;
    logic          allset_reg, allset_next;
    logic [4:0]    seed_reg, seed_next;
    logic [63:0]   h_reg, h_next, k_reg, k_next;
    logic [MW-1:0] rem_reg, rem_next, modulus;
    logic [MW:0]   div_trial;
    logic [5:0]    div_cnt_reg, div_cnt_next;
    logic [RCW-1:0] clr_reg, clr_next;
    logic          m_valid_reg, m_valid_next;
    logic [1:0]    m_data_reg, m_data_next;

    logic [7:0]    kbuf [MAX_KMER];
    logic [AW-1:0] rd_a, rd_b;
    logic [7:0]    kd_a_reg, kd_b_reg;
    logic          kb_we;

    logic [63:0]   store [ROWS];
    logic          st_we;
    logic [RW-1:0] st_addr;
    logic [63:0]   st_wdata, st_rd_reg;

    logic          mul_start, mul_done;
    logic [63:0]   mul_a, mul_prod;
    logic [7:0]    bval, rc;
    logic [CW-1:0] ridx;

    kbf_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    // configuration port
    assign pready = 1'b1;
    always_comb begin
        case (paddr[3:2])
            kbf_pkg::REG_KMER_LEN:    prdata = 32'(kmer_len_reg);
            kbf_pkg::REG_HASH_COUNT:  prdata = 32'(hash_count_reg);
            kbf_pkg::REG_FILTER_SIZE: prdata = 32'(filter_size_reg);
            default:                  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kmer_len_reg    <= kbf_pkg::KMER_LEN_RST;
            hash_count_reg  <= kbf_pkg::HASH_COUNT_RST;
            filter_size_reg <= kbf_pkg::FILTER_SIZE_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                kbf_pkg::REG_KMER_LEN:    kmer_len_reg    <= pwdata[6:0];
                kbf_pkg::REG_HASH_COUNT:  hash_count_reg  <= pwdata[4:0];
                kbf_pkg::REG_FILTER_SIZE: filter_size_reg <= pwdata[20:0];
                default: ;
            endcase
        end
    end

    assign modulus = (filter_size_reg == 21'd0 || MW'(filter_size_reg) > MW'(FILTER_BITS))
                     ? MW'(FILTER_BITS) : MW'(filter_size_reg);

    assign cnt_inc = (cnt_reg < CW'(MAX_KMER + 1)) ? cnt_reg + CW'(1) : cnt_reg;
    assign len_bad = (kmer_len_reg == 7'd0) || (LW'(kmer_len_reg) > LW'(MAX_KMER))
                     || (LW'(kmer_len_reg) != LW'(cnt_inc));
    assign idx_inc = idx_reg + CW'(1);
    assign ridx    = len_reg - CW'(1) - idx_reg;
    assign rc      = kbf_pkg::comp_base(kd_b_reg);
    assign bval    = flip_reg ? kbf_pkg::comp_base(kd_a_reg) : kd_a_reg;
    assign div_trial = {rem_reg, h_reg[63]};
    assign st_addr = (state_reg == kbf_pkg::ST_CLEAR) ? clr_reg[RW-1:0] : RW'(rem_reg >> 6);

    always_comb begin
        rd_a = idx_reg[AW-1:0];
        rd_b = ridx[AW-1:0];
        if (state_reg == kbf_pkg::ST_BRD && flip_reg) begin
            rd_a = ridx[AW-1:0];
        end
    end

    assign kb_we    = (state_reg == kbf_pkg::ST_RECV) && s_tvalid
                      && (cnt_reg < CW'(MAX_KMER));
    assign s_tready = (state_reg == kbf_pkg::ST_RECV);

    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        cnt_next     = cnt_reg;
        len_next     = len_reg;
        idx_next     = idx_reg;
        cmd_next     = cmd_reg;
        err_next     = err_reg;
        flip_next    = flip_reg;
        allset_next  = allset_reg;
        seed_next    = seed_reg;
        h_next       = h_reg;
        k_next       = k_reg;
        rem_next     = rem_reg;
        div_cnt_next = div_cnt_reg;
        clr_next     = clr_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        mul_start    = 1'b0;
        mul_a        = h_reg;
        st_we        = 1'b0;
        st_wdata     = 64'd0;
        case (state_reg)
            kbf_pkg::ST_CLEAR: begin
                st_we    = 1'b1;
                clr_next = clr_reg + RCW'(1);
                if (clr_reg == RCW'(ROWS - 1)) begin
                    state_next = kbf_pkg::ST_RECV;
                end
            end
            kbf_pkg::ST_RECV: begin
                if (s_tvalid) begin
                    cnt_next = cnt_inc;
                    if (s_tlast) begin
                        cnt_next    = '0;
                        len_next    = cnt_inc;
                        cmd_next    = s_tuser;
                        err_next    = len_bad;
                        idx_next    = '0;
                        flip_next   = 1'b0;
                        seed_next   = 5'd0;
                        allset_next = 1'b1;
                        state_next  = len_bad ? kbf_pkg::ST_RESP : kbf_pkg::ST_CRD;
                    end
                end
            end
            kbf_pkg::ST_CRD: state_next = kbf_pkg::ST_CCMP;
            kbf_pkg::ST_CCMP: begin
                if (rc != kd_a_reg || idx_inc == len_reg) begin
                    flip_next  = (rc < kd_a_reg);
                    state_next = (hash_count_reg == 5'd0) ? kbf_pkg::ST_RESP
                                                          : kbf_pkg::ST_HINIT;
                end else begin
                    idx_next   = idx_inc;
                    state_next = kbf_pkg::ST_CRD;
                end
            end
            kbf_pkg::ST_HINIT: begin
                mul_a      = 64'(len_reg);
                mul_start  = 1'b1;
                ret_next   = kbf_pkg::ST_HSEED;
                state_next = kbf_pkg::ST_MUL;
            end
            kbf_pkg::ST_MUL: begin
                if (mul_done) begin
                    state_next = ret_reg;
                end
            end
            kbf_pkg::ST_HSEED: begin
                h_next     = 64'(seed_reg) ^ mul_prod;
                k_next     = 64'd0;
                idx_next   = '0;
                state_next = kbf_pkg::ST_BRD;
            end
            kbf_pkg::ST_BRD: state_next = kbf_pkg::ST_BSH;
            kbf_pkg::ST_BSH: begin
                k_next   = k_reg | (64'(bval) << {idx_reg[2:0], 3'd0});
                idx_next = idx_inc;
                if (idx_inc[2:0] == 3'd0) begin
                    mul_a      = k_next;
                    mul_start  = 1'b1;
                    ret_next   = kbf_pkg::ST_K1;
                    state_next = kbf_pkg::ST_MUL;
                end else if (idx_inc == len_reg) begin
                    mul_a      = h_reg ^ k_next;
                    mul_start  = 1'b1;
                    ret_next   = kbf_pkg::ST_HM;
                    state_next = kbf_pkg::ST_MUL;
                end else begin
                    state_next = kbf_pkg::ST_BRD;
                end
            end
            kbf_pkg::ST_K1: begin
                mul_a      = mul_prod ^ (mul_prod >> kbf_pkg::MIX_SHIFT);
                mul_start  = 1'b1;
                ret_next   = kbf_pkg::ST_K2;
                state_next = kbf_pkg::ST_MUL;
            end
            kbf_pkg::ST_K2: begin
                mul_a      = h_reg ^ mul_prod;
                mul_start  = 1'b1;
                ret_next   = kbf_pkg::ST_HM;
                state_next = kbf_pkg::ST_MUL;
            end
            kbf_pkg::ST_HM: begin
                h_next     = mul_prod;
                k_next     = 64'd0;
                state_next = (idx_reg == len_reg) ? kbf_pkg::ST_FIN1 : kbf_pkg::ST_BRD;
            end
            kbf_pkg::ST_FIN1: begin
                mul_a      = h_reg ^ (h_reg >> kbf_pkg::MIX_SHIFT);
                mul_start  = 1'b1;
                ret_next   = kbf_pkg::ST_FIN2;
                state_next = kbf_pkg::ST_MUL;
            end
            kbf_pkg::ST_FIN2: begin
                h_next       = mul_prod ^ (mul_prod >> kbf_pkg::MIX_SHIFT);
                rem_next     = '0;
                div_cnt_next = 6'd0;
                state_next   = kbf_pkg::ST_DIV;
            end
            kbf_pkg::ST_DIV: begin
                if (div_trial >= {1'b0, modulus}) begin
                    rem_next = MW'(div_trial - {1'b0, modulus});
                end else begin
                    rem_next = div_trial[MW-1:0];
                end
                h_next       = {h_reg[62:0], 1'b0};
                div_cnt_next = div_cnt_reg + 6'd1;
                if (div_cnt_reg == 6'd63) begin
                    state_next = kbf_pkg::ST_MRD;
                end
            end
            kbf_pkg::ST_MRD: state_next = kbf_pkg::ST_MUPD;
            kbf_pkg::ST_MUPD: begin
                seed_next  = seed_reg + 5'd1;
                state_next = (seed_next == hash_count_reg) ? kbf_pkg::ST_RESP
                                                           : kbf_pkg::ST_HINIT;
                if (cmd_reg == kbf_pkg::CMD_INSERT) begin
                    st_we    = 1'b1;
                    st_wdata = st_rd_reg | (64'd1 << rem_reg[5:0]);
                end else if (!st_rd_reg[rem_reg[5:0]]) begin
                    allset_next = 1'b0;
                    state_next  = kbf_pkg::ST_RESP;
                end
            end
            kbf_pkg::ST_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {err_reg, !err_reg && cmd_reg == kbf_pkg::CMD_QUERY
                                             && allset_reg};
                    state_next   = kbf_pkg::ST_RECV;
                end
            end
            default: state_next = kbf_pkg::ST_RECV;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= kbf_pkg::ST_CLEAR;
            ret_reg     <= kbf_pkg::ST_RECV;
            cnt_reg     <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            cnt_reg     <= cnt_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg     <= len_next;
        idx_reg     <= idx_next;
        cmd_reg     <= cmd_next;
        err_reg     <= err_next;
        flip_reg    <= flip_next;
        allset_reg  <= allset_next;
        seed_reg    <= seed_next;
        h_reg       <= h_next;
        k_reg       <= k_next;
        rem_reg     <= rem_next;
        div_cnt_reg <= div_cnt_next;
        m_data_reg  <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (kb_we) begin
            kbuf[cnt_reg[AW-1:0]] <= s_tdata;
        end
        kd_a_reg <= kbuf[rd_a];
        kd_b_reg <= kbuf[rd_b];
    end

    always_ff @(posedge aclk) begin
        if (st_we) begin
            store[st_addr] <= st_wdata;
        end
        st_rd_reg <= store[st_addr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_data_reg};

endmodule
